@@ rtl/svp_pkg.sv @@
// svp_pkg: constants, operation codes, register indexes and the types shared
// by the sample voice player and its serial multiplier
// no dependencies
package svp_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int LEN_W       = 13;
    localparam int SMP_W       = 16;
    localparam int VOL_W       = 16;
    localparam int ENV_W       = 17;
    localparam int LOAD_ADDR_W = 12;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LEGATO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'd1;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_NOTEOFF = 2'd2;
    localparam logic [1:0] OP_LOAD    = 2'd3;

    localparam logic [ENV_W-1:0] ENV_ONE   = 17'd65536;
    localparam logic [ENV_W-1:0] ENV_DECAY = 17'd64881;
    localparam logic [ENV_W-1:0] ENV_STOP  = 17'd66;
    localparam logic [VOL_W-1:0] VOL_RESET = 16'd3277;
    localparam int               NEAR_ZERO = 32;

    // serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = 18;
    localparam int MUL_ACC_W = MUL_A_W + 1;
    localparam int MUL_P_W   = 20;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // product >>> 16 is offset by three times this so the divide by three sees
    // a non-negative value
    localparam int DIV_W      = 19;
    localparam int DIV_OFFSET = 98304;
    localparam int DIV_BIAS   = 32768;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic        [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] p;
    } t_mul_rsp;

endpackage

@@ rtl/svp_if.sv @@
// svp_if: valid/ready channels of the sample voice player (input items,
// result items, configuration writes)
// depends on svp_pkg
interface svp_in_if
    import svp_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic signed [SMP_W-1:0]       mix_in;
    logic [VOL_W-1:0]              level;
    logic [LOAD_ADDR_W-1:0]        load_address;
    logic signed [SMP_W-1:0]       load_value;

    modport source (output valid, operation, mix_in, level, load_address, load_value,
                    input ready);
    modport sink   (input valid, operation, mix_in, level, load_address, load_value,
                    output ready);
endinterface

interface svp_out_if
    import svp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] mixed_out;
    logic                    voice_active;

    modport source (output valid, mixed_out, voice_active, input ready);
    modport sink   (input valid, mixed_out, voice_active, output ready);
endinterface

interface svp_cfg_if
    import svp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/svp_ram.sv @@
// svp_ram: generic single-write, single-read memory with registered read data
// no dependencies
module svp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/svp_mul.sv @@
// svp_mul: bit-serial shift-add multiplier, one multiplier bit per cycle,
// returns the product shifted right by 16
// depends on svp_pkg
module svp_mul
    import svp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [MUL_CNT_W-1:0]              r_cnt;
    logic signed [MUL_A_W-1:0]         r_m;
    logic [MUL_ACC_W+MUL_B_W-1:0]      r_p;
    logic signed [MUL_ACC_W-1:0]       n_sum;

    assign n_sum = $signed(r_p[MUL_ACC_W+MUL_B_W-1:MUL_B_W])
                 + (r_p[0] ? MUL_ACC_W'(r_m) : MUL_ACC_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m <= i_req.a;
            r_p <= {MUL_ACC_W'(0), i_req.b};
        end else if (r_busy) begin
            r_p <= {n_sum[MUL_ACC_W-1], n_sum, r_p[MUL_B_W-1:1]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = $signed(r_p[MUL_P_W+15:16]);

endmodule

@@ rtl/sample_voice_player.sv @@
// sample_voice_player: top level of the one-shot sample voice mixer
// depends on svp_pkg, svp_if, svp_ram, svp_mul
//
// Load, trigger and note-off items are handled in the idle state, and a tick
// while the voice is idle goes straight to finish. A tick while playing runs
// read, check, gain, product, divide and sum, plus a decay step in a release,
// and returns to read when a pending legato retrigger rereads the sample memory.
// Its length is set by the bit-serial multiplier (envelope decay, gain, sample
// product) and by the one-bit-per-cycle divide by three.
// A new item is taken while the previous result waits at the output register.
module sample_voice_player
    import svp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    svp_in_if.sink         i_in,
    svp_out_if.source      o_out,
    svp_cfg_if.sink        i_cfg
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_DECAY = 4'd3;
    localparam logic [3:0] S_GAIN  = 4'd4;
    localparam logic [3:0] S_PROD  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]              r_state;
    logic                    r_legato;
    logic [LEN_W-1:0]        r_len_cfg;
    logic [ADDR_W-1:0]       r_pos;
    logic [ENV_W-1:0]        r_env;
    logic [VOL_W-1:0]        r_vol;
    logic [VOL_W-1:0]        r_pend_vol;
    logic                    r_playing;
    logic                    r_released;
    logic                    r_retrig;

    logic [ADDR_W-1:0]       r_idx;
    logic signed [SMP_W-1:0] r_mix;
    logic signed [SMP_W-1:0] r_smp;
    logic [DIV_W-1:0]        r_div;
    logic [1:0]              r_rem;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic signed [SMP_W-1:0] r_res;
    logic                    r_act;

    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_mixed;
    logic                    r_out_active;

    logic                    in_xfer;
    logic                    out_free;
    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        pos_ext;
    logic [ADDR_W-1:0]       idx_clamped;
    logic signed [SMP_W-1:0] rdata;
    logic                    near_zero;
    logic [1:0]              w;
    logic [VOL_W-1:0]        gain;
    logic [MUL_B_W-1:0]      gw;
    logic [DIV_W+1:0]        biased;
    logic [2:0]              div_t;
    logic                    div_ge;
    logic signed [SMP_W:0]   contrib;
    logic signed [SMP_W+1:0] sum;
    logic signed [SMP_W-1:0] sat;
    logic [LEN_W-1:0]        pos_next;
    logic                    note_end;
    logic                    ram_we;
    logic [SMP_W-1:0]        ram_rdata;
    t_mul_req                mul_req;
    t_mul_rsp                mul_rsp;

    svp_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_in.load_address)),
        .i_wdata (i_in.load_value),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    svp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign ram_we   = in_xfer && (i_in.operation == OP_LOAD)
                   && (32'(i_in.load_address) < 32'(MAX_SAMPLES));

    // effective length, held in 2..MAX_SAMPLES
    always_comb begin
        if (r_len_cfg < LEN_W'(2)) begin
            len = LEN_W'(2);
        end else if (r_len_cfg > LEN_W'(MAX_SAMPLES)) begin
            len = LEN_W'(MAX_SAMPLES);
        end else begin
            len = r_len_cfg;
        end
    end

    assign pos_ext     = LEN_W'(r_pos);
    assign idx_clamped = (pos_ext >= len) ? ADDR_W'(len - 1'b1) : r_pos;

    assign rdata     = $signed(ram_rdata);
    assign near_zero = rdata inside {[-SMP_W'(NEAR_ZERO) : SMP_W'(NEAR_ZERO)]};

    // fade weight
    always_comb begin
        if (r_idx < ADDR_W'(3)) begin
            w = 2'(r_idx) + 2'd1;
        end else if (LEN_W'(r_idx) + LEN_W'(3) > len) begin
            w = 2'(len - LEN_W'(r_idx));
        end else begin
            w = 2'd3;
        end
    end

    assign gain = mul_rsp.p[VOL_W-1:0];
    assign gw   = (w[0] ? MUL_B_W'(gain) : MUL_B_W'(0))
                + (w[1] ? {(MUL_B_W-1)'(gain), 1'b0} : MUL_B_W'(0));

    assign biased = (DIV_W+2)'(mul_rsp.p) + (DIV_W+2)'(DIV_OFFSET);

    assign div_t  = {r_rem, r_div[DIV_W-1]};
    assign div_ge = (div_t >= 3'd3);

    assign contrib = $signed({1'b0, r_div[SMP_W-1:0]}) - (SMP_W+1)'(DIV_BIAS);
    assign sum     = (SMP_W+2)'(r_mix) + (SMP_W+2)'(contrib);

    always_comb begin
        if (sum > (SMP_W+2)'(32767)) begin
            sat = 16'sh7fff;
        end else if (sum < -(SMP_W+2)'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = sum[SMP_W-1:0];
        end
    end

    assign pos_next = LEN_W'(r_idx) + 1'b1;
    assign note_end = (pos_next >= len - 1'b1) || (r_env < ENV_STOP);

    // multiplier launches
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (r_state)
            S_CHK: begin
                if (!(r_retrig && near_zero)) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = $signed({1'b0, r_env});
                    mul_req.b     = r_released ? MUL_B_W'(ENV_DECAY) : MUL_B_W'(r_vol);
                end
            end
            S_DECAY: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = $signed({1'b0, mul_rsp.p[ENV_W-1:0]});
                    mul_req.b     = MUL_B_W'(r_vol);
                end
            end
            S_GAIN: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(r_smp);
                    mul_req.b     = gw;
                end
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legato  <= 1'b0;
            r_len_cfg <= LEN_W'(MAX_SAMPLES);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_LEGATO: r_legato  <= i_cfg.data[0];
                REG_LENGTH: r_len_cfg <= LEN_W'(i_cfg.data);
                default:    r_legato  <= r_legato;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // sequencer and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_env      <= ENV_ONE;
            r_vol      <= VOL_RESET;
            r_pend_vol <= '0;
            r_playing  <= 1'b0;
            r_released <= 1'b0;
            r_retrig   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_in.operation)
                            OP_TICK: begin
                                r_state <= r_playing ? S_RD : S_FIN;
                            end
                            OP_TRIGGER: begin
                                if (r_legato && r_playing) begin
                                    r_retrig   <= 1'b1;
                                    r_pend_vol <= i_in.level;
                                end else begin
                                    r_retrig   <= 1'b0;
                                    r_pos      <= '0;
                                    r_env      <= ENV_ONE;
                                    r_vol      <= i_in.level;
                                    r_playing  <= 1'b1;
                                    r_released <= 1'b0;
                                end
                            end
                            OP_NOTEOFF: begin
                                if (!r_legato) begin
                                    r_released <= 1'b1;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_retrig && near_zero) begin
                        // restart on a near-zero sample, then reread position zero
                        r_retrig   <= 1'b0;
                        r_pos      <= '0;
                        r_env      <= ENV_ONE;
                        r_vol      <= r_pend_vol;
                        r_released <= 1'b0;
                        r_state    <= S_RD;
                    end else begin
                        r_state <= r_released ? S_DECAY : S_GAIN;
                    end
                end
                S_DECAY: begin
                    if (mul_rsp.done) begin
                        r_env   <= mul_rsp.p[ENV_W-1:0];
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (mul_rsp.done) begin
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    if (mul_rsp.done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (note_end) begin
                        r_pos <= '0;
                        if (r_retrig) begin
                            r_retrig   <= 1'b0;
                            r_env      <= ENV_ONE;
                            r_vol      <= r_pend_vol;
                            r_released <= 1'b0;
                        end else begin
                            r_playing <= 1'b0;
                        end
                    end else begin
                        r_pos <= ADDR_W'(pos_next);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx <= idx_clamped;
                r_mix <= i_in.mix_in;
                r_res <= i_in.mix_in;
                r_act <= 1'b0;
            end
            S_CHK: begin
                r_smp <= rdata;
                if (r_retrig && near_zero) begin
                    r_idx <= '0;
                end
            end
            S_PROD: begin
                r_div <= biased[DIV_W-1:0];
                r_rem <= 2'd0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? 2'(div_t - 3'd3) : div_t[1:0];
                r_div <= {r_div[DIV_W-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_SUM: begin
                r_res <= sat;
                r_act <= !note_end || r_retrig;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_mixed  <= r_res;
            r_out_active <= r_act;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.mixed_out    = r_out_mixed;
    assign o_out.voice_active = r_out_active;

endmodule

@@ tb/sv/sample_voice_player_tb.sv @@
// sample_voice_player_tb: self-checking bench for the one-shot sample voice mixer,
// a directed table followed by random note sequences under several register settings
// depends on svp_pkg, svp_if and the sample_voice_player rtl
module sample_voice_player_tb;
    import svp_pkg::*;

    localparam longint      FADE_DIV      = 3 * 65536;
    localparam logic [16:0] ENV_FULL      = 17'd65536;
    localparam logic [16:0] ENV_DECAY_MUL = 17'd64881;
    localparam logic [16:0] ENV_FLOOR     = 17'd66;
    localparam int          QUIET_MAG     = 32;
    localparam int          SETTLE_CYCLES = 128;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          PHASE_ITEMS   = 70;
    localparam int          NUM_PHASES    = 10;

    localparam logic [NUM_PHASES-1:0] PHASE_LEGATO = 10'b1010101010;
    localparam logic [12:0] PHASE_LEN [NUM_PHASES] = '{
        13'd2, 13'd8, 13'd1, 13'd3, 13'd8191, 13'd4096, 13'd0, 13'd5, 13'd17, 13'd2
    };

    typedef struct {
        logic [1:0]              op;
        logic signed [SMP_W-1:0] mix;
        logic [VOL_W-1:0]        level;
        logic [LOAD_ADDR_W-1:0]  addr;
        logic signed [SMP_W-1:0] value;
    } t_voice_item;

    typedef struct {
        logic signed [SMP_W-1:0] mixed;
        logic                    active;
    } t_mix_result;

    typedef struct {
        t_voice_item item;
        logic        fixed;
        t_mix_result want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    svp_in_if  in_ch ();
    svp_out_if out_ch ();
    svp_cfg_if cfg_ch ();

    sample_voice_player dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // voice state as predicted
    logic signed [SMP_W-1:0] voice_mem [MAX_SAMPLES];
    bit                      word_loaded [MAX_SAMPLES];
    logic [11:0]             play_pos    = '0;
    logic [16:0]             env_level   = ENV_FULL;
    logic [VOL_W-1:0]        note_vol    = 16'd3277;
    logic [VOL_W-1:0]        held_vol    = '0;
    bit                      playing     = 1'b0;
    bit                      released    = 1'b0;
    bit                      retrig_wait = 1'b0;
    bit                      legato_on   = 1'b0;
    logic [12:0]             len_reg     = 13'd4096;

    t_mix_result due_mixes [$];
    int unsigned mismatches  = 0;
    int unsigned items_sent  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left [2] = '{0, 0};

    // extremes, all-bit patterns and the fade end; idle ticks use fixed results, others the predictor
    t_directed_row plan [24] = '{
        '{'{OP_TICK,    16'sh7fff, 16'd0,     12'd0,    16'sd0},    1'b1, '{16'sh7fff, 1'b0}},
        '{'{OP_TICK,    16'sh8000, 16'd0,     12'd0,    16'sd0},    1'b1, '{16'sh8000, 1'b0}},
        '{'{OP_NOTEOFF, 16'sd0,    16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd4095, 16'shffff}, 1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd0,    16'sh7fff}, 1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd1,    16'sh8000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd2,    16'sh7fff}, 1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd3,    16'sh8000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd4,    16'sd20},   1'b0, '{16'sd0, 1'b0}},
        '{'{OP_LOAD,    16'sd0,    16'd0,     12'd5,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TRIGGER, 16'sd0,    16'hffff,  12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sh7fff, 16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sh8000, 16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sh7fff, 16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    -16'sd1,   16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sd0,    16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sd1234, 16'd0,     12'd0,    16'sd0},    1'b1, '{16'sd1234, 1'b0}},
        '{'{OP_TRIGGER, 16'sd0,    16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sh8000, 16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_NOTEOFF, 16'sd0,    16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sh7fff, 16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TRIGGER, 16'sd0,    16'h8000,  12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sd0,    16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}},
        '{'{OP_TICK,    16'sd0,    16'd0,     12'd0,    16'sd0},    1'b0, '{16'sd0, 1'b0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [12:0] eff_len();
        if (len_reg < 13'd2) return 13'd2;
        if (len_reg > 13'(MAX_SAMPLES)) return 13'(MAX_SAMPLES);
        return len_reg;
    endfunction

    function automatic void start_voice(logic [VOL_W-1:0] v);
        play_pos  = '0;
        env_level = ENV_FULL;
        note_vol  = v;
        playing   = 1'b1;
        released  = 1'b0;
    endfunction

    function automatic bit voice_mix_step(input t_voice_item it, output t_mix_result res);
        logic [12:0]             eff;
        logic [12:0]             idx;
        logic [12:0]             nxt;
        logic signed [SMP_W-1:0] smp;
        logic [15:0]             gain;
        logic [1:0]              wgt;
        longint                  prod;
        longint                  quo;
        longint                  total;
        res.mixed  = it.mix;
        res.active = 1'b0;
        case (it.op)
            OP_TRIGGER: begin
                if (legato_on && playing) begin
                    retrig_wait = 1'b1;
                    held_vol    = it.level;
                end else begin
                    retrig_wait = 1'b0;
                    start_voice(it.level);
                end
            end
            OP_NOTEOFF: begin
                if (!legato_on) released = 1'b1;
            end
            OP_LOAD: begin
                voice_mem[it.addr]   = it.value;
                word_loaded[it.addr] = 1'b1;
            end
            default: begin
                if (playing) begin
                    eff = eff_len();
                    idx = (13'(play_pos) >= eff) ? eff - 13'd1 : 13'(play_pos);
                    smp = voice_mem[idx];
                    if (retrig_wait && smp >= -QUIET_MAG && smp <= QUIET_MAG) begin
                        retrig_wait = 1'b0;
                        start_voice(held_vol);
                        idx = '0;
                        smp = voice_mem[0];
                    end else if (released) begin
                        env_level = 17'((64'(env_level) * 64'(ENV_DECAY_MUL)) >> 16);
                    end
                    gain = 16'((64'(env_level) * 64'(note_vol)) >> 16);
                    if (idx < 13'd3) wgt = 2'(idx + 13'd1);
                    else if (idx + 13'd3 > eff) wgt = 2'(eff - idx);
                    else wgt = 2'd3;
                    prod = longint'(smp) * longint'(gain) * longint'(wgt);
                    quo  = prod / FADE_DIV;
                    if (prod < 0 && (prod % FADE_DIV) != 0) quo = quo - 1;
                    total = longint'(it.mix) + quo;
                    if (total > 32767) total = 32767;
                    else if (total < -32768) total = -32768;
                    res.mixed = 16'(total);
                    nxt = idx + 13'd1;
                    play_pos = nxt[11:0];
                    if (nxt >= eff - 13'd1 || env_level < ENV_FLOOR) begin
                        playing  = 1'b0;
                        play_pos = '0;
                        if (retrig_wait) begin
                            retrig_wait = 1'b0;
                            start_voice(held_vol);
                        end
                    end
                end
                res.active = playing;
            end
        endcase
        return it.op == OP_TICK;
    endfunction

    function automatic int unsigned idle_draw(int side);
        if (burst_left[side] > 0) begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // near-zero words are common so legato retriggers resolve
    function automatic logic signed [SMP_W-1:0] audio_word();
        case ($urandom_range(0, 5))
            0, 1:    return 16'(int'($urandom_range(0, 64)) - 32);
            2:       return 16'sh7fff;
            3:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_voice_item random_item(logic [1:0] op);
        t_voice_item it;
        it.op    = op;
        it.mix   = audio_word();
        it.addr  = 12'($urandom);
        it.value = audio_word();
        case ($urandom_range(0, 3))
            0:       it.level = '0;
            1:       it.level = '1;
            default: it.level = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic drive_item(input t_voice_item it);
        int unsigned gap;
        gap = idle_draw(0);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= it.op;
        in_ch.mix_in       <= it.mix;
        in_ch.level        <= it.level;
        in_ch.load_address <= it.addr;
        in_ch.load_value   <= it.value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_voice_item(input t_voice_item it, input logic fixed,
                                   input t_mix_result want);
        t_voice_item fill;
        t_mix_result res;
        logic [12:0] rd;
        // words about to be read are loaded first, never-written words stay unread
        if (it.op == OP_TICK && playing) begin
            rd = (13'(play_pos) >= eff_len()) ? eff_len() - 13'd1 : 13'(play_pos);
            for (int k = 0; k < 2; k++) begin
                fill      = random_item(OP_LOAD);
                fill.addr = (k == 0) ? rd[11:0] : 12'd0;
                if (!word_loaded[fill.addr]) begin
                    void'(voice_mix_step(fill, res));
                    drive_item(fill);
                end
            end
        end
        if (voice_mix_step(it, res)) due_mixes.push_back(fixed ? want : res);
        drive_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        if (idx == REG_LEGATO) legato_on = data[0];
        else len_reg = data;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (due_mixes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_mix_result none;
        int unsigned phase_start;
        int unsigned span;
        int unsigned roll;
        logic [1:0]  op;
        none = '{16'sd0, 1'b0};
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_TICK;
        in_ch.mix_in       = '0;
        in_ch.level        = '0;
        in_ch.load_address = '0;
        in_ch.load_value   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_LEGATO;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_LEGATO, 13'h1ffe);
        write_reg(REG_LENGTH, 13'd6);
        foreach (plan[r]) send_voice_item(plan[r].item, plan[r].fixed, plan[r].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_reg(REG_LEGATO, {12'($urandom), PHASE_LEGATO[ph]});
            write_reg(REG_LENGTH, PHASE_LEN[ph]);
            phase_start = items_sent;
            // long sample: a stretch of release deep into the sample
            if (!legato_on && eff_len() == 13'(MAX_SAMPLES)) begin
                send_voice_item(random_item(OP_TRIGGER), 1'b0, none);
                send_voice_item(random_item(OP_NOTEOFF), 1'b0, none);
                while (playing && items_sent - phase_start < PHASE_ITEMS) begin
                    send_voice_item(random_item(OP_TICK), 1'b0, none);
                end
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_voice_item(random_item(2'($urandom)), 1'b0, none);
                end else begin
                    send_voice_item(random_item(OP_TRIGGER), 1'b0, none);
                    span = $urandom_range(1, 40);
                    repeat (span) begin
                        roll = $urandom_range(0, 19);
                        if (roll == 0) op = OP_NOTEOFF;
                        else if (roll == 1) op = OP_TRIGGER;
                        else if (roll == 2) op = OP_LOAD;
                        else op = OP_TICK;
                        send_voice_item(random_item(op), 1'b0, none);
                    end
                end
            end
        end

        drain();
        if (mismatches == 0 && due_mixes.size() == 0) begin
            $display("** sample_voice_player: PASSED **");
        end else begin
            $display("** sample_voice_player: FAILED **");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        t_mix_result want;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = idle_draw(1);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            if (due_mixes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer, mixed_out %0d voice_active %0b",
                         $time, out_ch.mixed_out, out_ch.voice_active);
            end else begin
                want = due_mixes.pop_front();
                if (out_ch.mixed_out !== want.mixed) begin
                    mismatches++;
                    $display("%0t: mixed_out expected %0d actual %0d",
                             $time, want.mixed, out_ch.mixed_out);
                end
                if (out_ch.voice_active !== want.active) begin
                    mismatches++;
                    $display("%0t: voice_active expected %0b actual %0b",
                             $time, want.active, out_ch.voice_active);
                end
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** sample_voice_player: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
rtl/svp_pkg.sv
rtl/svp_if.sv
rtl/svp_ram.sv
rtl/svp_mul.sv
rtl/sample_voice_player.sv
tb/sv/sample_voice_player_tb.sv
